[src/assert_macros.svh]
// Assertion macros used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/ffsa_pkg.sv]
// Types and constants of the first-fit slot allocator.
package ffsa_pkg;

	localparam int unsigned NUM_SLOTS_DEF  = 512;
	localparam int unsigned SLOT_BYTES_DEF = 16;
	localparam int unsigned DIVD_W         = 16;
	localparam int unsigned ADDR_W         = 13;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOMEM  = 2'd1,
		ST_BADPTR = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_FREE = 2'd0,
		KIND_USED = 2'd1,
		KIND_BASE = 2'd2
	} kind_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [DIVD_W-1:0] request_bytes;
		logic [DIVD_W-1:0] free_address;
	} in_item_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] granted_address;
	} out_item_t;

	// Write controls from the sequencer to the slot store
	typedef struct packed {
		logic  kind_we;
		logic  len_we;
		kind_t wkind;
	} store_cmd_t;

endpackage

[src/first_fit_slot_allocator.sv]
// Top level of the first-fit slot allocator: sequencer, divider and slot store.
//
//  channel   ports                     handshake
//  ------    ------------------------  -----------------------------------
//  command   start, busy, item         beat taken when start && !busy
//  result    done, result              beat shown for one cycle, done high
//
// Each command: the divider (quotient step, then remainder step), range checks, then
//   allocate: scan one slot per cycle until a free run of the needed length is
//             found or all slots are passed, then mark the slots of the run.
//   free:     lookup of the base slot, then clear the slots of its run in turn.
// After reset the kind memory is swept to free, with busy high.
// The result has no back-pressure; busy falls in the cycle done is high.
`include "assert_macros.svh"

module first_fit_slot_allocator #(
	parameter int unsigned NUM_SLOTS  = ffsa_pkg::NUM_SLOTS_DEF,
	parameter int unsigned SLOT_BYTES = ffsa_pkg::SLOT_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ffsa_pkg::in_item_t  item,
	output logic                done,
	output ffsa_pkg::out_item_t result
);
	import ffsa_pkg::*;

	localparam int unsigned IDX_W  = $clog2(NUM_SLOTS);
	localparam int unsigned LEN_W  = IDX_W + 1;
	localparam int unsigned SB_W   = $clog2(SLOT_BYTES + 1);
	localparam int unsigned PROD_W = IDX_W + SB_W;

	typedef enum logic [8:0] {
		S_INIT  = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_DIV   = 9'b000000100,
		S_CHECK = 9'b000001000,
		S_SCAN  = 9'b000010000,
		S_MARK  = 9'b000100000,
		S_FRD   = 9'b001000000,
		S_FCHK  = 9'b010000000,
		S_CLR   = 9'b100000000
	} state_t;

	state_t            state_q;
	cmd_t              cmd_q;
	logic [IDX_W-1:0]  init_idx_q;
	logic [LEN_W-1:0]  need_q;
	logic [LEN_W-1:0]  scan_idx_q;
	logic              chk_vld_q;
	logic [IDX_W-1:0]  chk_idx_q;
	logic [LEN_W-1:0]  run_q;
	logic [IDX_W-1:0]  start_q;
	logic [IDX_W-1:0]  mark_idx_q;
	logic [LEN_W-1:0]  mark_cnt_q;
	logic [IDX_W-1:0]  idx_q;
	logic [LEN_W-1:0]  clr_cnt_q;
	logic              done_q;
	out_item_t         res_q;

	logic              accept_w;
	logic              div_done;
	logic [DIVD_W-1:0] div_quo;
	logic [SB_W-1:0]   div_rem;
	logic [DIVD_W:0]   need_w;
	logic              issue_w;
	logic [LEN_W-1:0]  run_next_w;
	logic [IDX_W-1:0]  start_w;
	logic [PROD_W-1:0] prod_w;
	store_cmd_t        st_cmd;
	logic [IDX_W-1:0]  st_waddr;
	logic [IDX_W-1:0]  st_raddr;
	kind_t             st_rkind;
	logic [LEN_W-1:0]  st_rlen;

	assign accept_w = start && (state_q == S_IDLE);

	// shared divider: slot count for allocate, slot index and offset for free
	ffsa_div #(
		.DIVISOR (SLOT_BYTES),
		.RES_W   (SB_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept_w),
		.dividend  ((item.cmd == CMD_ALLOC) ? item.request_bytes : item.free_address),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// round up to whole slots
	assign need_w = {1'b0, div_quo} + (DIVD_W+1)'(div_rem != '0);

	// scan helpers
	assign issue_w    = (scan_idx_q < LEN_W'(NUM_SLOTS));
	assign run_next_w = run_q + 1'b1;
	assign start_w    = IDX_W'((LEN_W'(chk_idx_q) + LEN_W'(1)) - need_q);
	assign prod_w     = PROD_W'(start_q) * PROD_W'(SLOT_BYTES);

	// store port steering
	always_comb begin
		st_cmd   = '{kind_we: 1'b0, len_we: 1'b0, wkind: KIND_FREE};
		st_waddr = idx_q;
		case (state_q)
			S_INIT: begin
				st_cmd.kind_we = 1'b1;
				st_waddr       = init_idx_q;
			end
			S_MARK: begin
				st_cmd.kind_we = 1'b1;
				st_cmd.len_we  = (mark_idx_q == start_q);
				st_cmd.wkind   = (mark_idx_q == start_q) ? KIND_BASE : KIND_USED;
				st_waddr       = mark_idx_q;
			end
			S_CLR: begin
				st_cmd.kind_we = 1'b1;
				st_waddr       = idx_q;
			end
			default: begin
				st_cmd = '{kind_we: 1'b0, len_we: 1'b0, wkind: KIND_FREE};
			end
		endcase
	end

	assign st_raddr = (state_q == S_SCAN) ? scan_idx_q[IDX_W-1:0] : idx_q;

	ffsa_slot_store #(
		.NUM_SLOTS (NUM_SLOTS),
		.IDX_W     (IDX_W),
		.LEN_W     (LEN_W)
	) u_store (
		.clk   (clk),
		.wr    (st_cmd),
		.waddr (st_waddr),
		.wlen  (need_q),
		.raddr (st_raddr),
		.rkind (st_rkind),
		.rlen  (st_rlen)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			init_idx_q <= '0;
			done_q     <= 1'b0;
			chk_vld_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_INIT: begin
					init_idx_q <= init_idx_q + 1'b1;
					if (init_idx_q == IDX_W'(NUM_SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (cmd_q == CMD_ALLOC) begin
						if (need_w == '0 || need_w > (DIVD_W+1)'(NUM_SLOTS)) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							chk_vld_q <= 1'b0;
							state_q   <= S_SCAN;
						end
					end else begin
						if (div_rem != '0 || {1'b0, div_quo} >= (DIVD_W+1)'(NUM_SLOTS)) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_FRD;
						end
					end
				end
				S_SCAN: begin
					chk_vld_q <= issue_w;
					if (chk_vld_q && st_rkind == KIND_FREE && run_next_w == need_q) begin
						state_q <= S_MARK;
					end else if (!chk_vld_q && !issue_w) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_MARK: begin
					if (mark_cnt_q == LEN_W'(1)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_FRD: begin
					state_q <= S_FCHK;
				end
				S_FCHK: begin
					if (st_rkind != KIND_BASE) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_CLR;
					end
				end
				S_CLR: begin
					if (clr_cnt_q <= LEN_W'(1) || idx_q == IDX_W'(NUM_SLOTS - 1)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// working registers and result
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_q <= item.cmd;
				end
			end
			S_CHECK: begin
				if (cmd_q == CMD_ALLOC) begin
					need_q     <= LEN_W'(need_w);
					scan_idx_q <= '0;
					run_q      <= '0;
					res_q      <= '{status: ST_NOMEM, granted_address: '0};
				end else begin
					idx_q <= IDX_W'(div_quo);
					res_q <= '{status: ST_BADPTR, granted_address: '0};
				end
			end
			S_SCAN: begin
				if (issue_w) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
				chk_idx_q <= scan_idx_q[IDX_W-1:0];
				if (chk_vld_q) begin
					run_q <= (st_rkind == KIND_FREE) ? run_next_w : '0;
				end
				start_q    <= start_w;
				mark_idx_q <= start_w;
				mark_cnt_q <= need_q;
			end
			S_MARK: begin
				mark_idx_q <= mark_idx_q + 1'b1;
				mark_cnt_q <= mark_cnt_q - 1'b1;
				res_q      <= '{status: ST_OK, granted_address: ADDR_W'(prod_w)};
			end
			S_FCHK: begin
				clr_cnt_q <= st_rlen;
			end
			S_CLR: begin
				idx_q     <= idx_q + 1'b1;
				clr_cnt_q <= clr_cnt_q - 1'b1;
				res_q     <= '{status: ST_OK, granted_address: '0};
			end
			default: begin
				cmd_q <= cmd_q;
			end
		endcase
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	// checks
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accepted beat did not raise busy")
	`ASSERT_IMPLIES(a_done_after_work, clk, arst_n, done, $past(busy), "result without a command in flight")
	`ASSERT_IMPLIES(a_fail_addr_zero, clk, arst_n, done && result.status != ST_OK, result.granted_address == '0, "failed result carries an address")
	`ASSERT_IMPLIES(a_write_states, clk, arst_n, st_cmd.kind_we, state_q == S_INIT || state_q == S_MARK || state_q == S_CLR, "slot store written outside init or mark or clear")

endmodule

[src/ffsa_div.sv]
// Divider by a fixed divisor: reciprocal multiply, then remainder, on one shared multiplier.
module ffsa_div #(
	parameter int unsigned DIVISOR = ffsa_pkg::SLOT_BYTES_DEF,
	parameter int unsigned RES_W   = $clog2(DIVISOR + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ffsa_pkg::DIVD_W-1:0] dividend,
	output logic                        done,
	output logic [ffsa_pkg::DIVD_W-1:0] quotient,
	output logic [RES_W-1:0]            remainder
);
	import ffsa_pkg::*;

	// q = (x * M) >> S is exact for every x below 2**DIVD_W with these constants
	localparam int unsigned     REC_L  = $clog2(DIVISOR);
	localparam int unsigned     REC_S  = DIVD_W + REC_L;
	localparam int unsigned     REC_W  = DIVD_W + 1;
	localparam int unsigned     PROD_W = DIVD_W + REC_W;
	localparam longint unsigned REC_M  =
		((64'd1 << REC_S) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

	typedef enum logic [2:0] {
		D_IDLE = 3'b001,
		D_QUO  = 3'b010,
		D_REM  = 3'b100
	} div_state_t;

	div_state_t        div_state_q;
	logic              done_q;
	logic [DIVD_W-1:0] x_q;
	logic [DIVD_W-1:0] quo_q;
	logic [RES_W-1:0]  rem_q;
	logic [DIVD_W-1:0] mul_a_w;
	logic [REC_W-1:0]  mul_b_w;
	logic [PROD_W-1:0] mul_p_w;

	// shared multiplier: x * M for the quotient, then q * DIVISOR for the remainder
	assign mul_a_w = (div_state_q == D_QUO) ? x_q : quo_q;
	assign mul_b_w = (div_state_q == D_QUO) ? REC_W'(REC_M) : REC_W'(DIVISOR);
	assign mul_p_w = PROD_W'(mul_a_w) * PROD_W'(mul_b_w);

	// step sequencer and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_state_q <= D_IDLE;
			done_q      <= 1'b0;
		end else begin
			case (div_state_q)
				D_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						div_state_q <= D_QUO;
					end
				end
				D_QUO: begin
					done_q      <= 1'b0;
					div_state_q <= D_REM;
				end
				D_REM: begin
					done_q      <= 1'b1;
					div_state_q <= D_IDLE;
				end
				default: begin
					done_q      <= 1'b0;
					div_state_q <= D_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= dividend;
		end
		if (div_state_q == D_QUO) begin
			quo_q <= DIVD_W'(mul_p_w >> REC_S);
		end
		if (div_state_q == D_REM) begin
			rem_q <= RES_W'(x_q - DIVD_W'(mul_p_w));
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

[src/ffsa_slot_store.sv]
// Slot kind and run length memories, one write and one registered read port.
module ffsa_slot_store #(
	parameter int unsigned NUM_SLOTS = ffsa_pkg::NUM_SLOTS_DEF,
	parameter int unsigned IDX_W     = $clog2(NUM_SLOTS),
	parameter int unsigned LEN_W     = IDX_W + 1
) (
	input  logic                 clk,
	input  ffsa_pkg::store_cmd_t wr,
	input  logic [IDX_W-1:0]     waddr,
	input  logic [LEN_W-1:0]     wlen,
	input  logic [IDX_W-1:0]     raddr,
	output ffsa_pkg::kind_t      rkind,
	output logic [LEN_W-1:0]     rlen
);
	import ffsa_pkg::*;

	kind_t            kind_mem [NUM_SLOTS];
	logic [LEN_W-1:0] len_mem  [NUM_SLOTS];
	kind_t            rkind_q;
	logic [LEN_W-1:0] rlen_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr.kind_we) begin
			kind_mem[waddr] <= wr.wkind;
		end
		if (wr.len_we) begin
			len_mem[waddr] <= wlen;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rkind_q <= kind_mem[raddr];
		rlen_q  <= len_mem[raddr];
	end

	assign rkind = rkind_q;
	assign rlen  = rlen_q;

endmodule
